// ===== src/nearest_neighbor_resize_mapper_assert.svh =====
// Assertion macros for the nearest neighbor resize mapper.
`ifndef NEAREST_NEIGHBOR_RESIZE_MAPPER_ASSERT_SVH
`define NEAREST_NEIGHBOR_RESIZE_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define NNRM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NNRM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define NNRM_ASSERT(label, prop, msg)
`define NNRM_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== src/nnrm_pkg.sv =====
// Shared widths, register indexes and divider state type for the nearest neighbor resize mapper.
package nnrm_pkg;
    localparam int MAX_SIZE = 4096;
    localparam int COORD_W  = $clog2(MAX_SIZE);
    localparam int REG_W    = COORD_W + 1;
    localparam int PROD_W   = COORD_W + REG_W;
    localparam int NUM_W    = PROD_W + 2;
    localparam int DIV_W    = REG_W + 1;
    localparam int REM_W    = DIV_W + 1;
    localparam int IDX_W    = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_DST_WIDTH  = 3'd0,
        REG_DST_HEIGHT = 3'd1,
        REG_SRC_WIDTH  = 3'd2,
        REG_SRC_HEIGHT = 3'd3,
        REG_DST_ROOM_X = 3'd4,
        REG_DST_ROOM_Y = 3'd5,
        REG_SRC_ROOM_X = 3'd6,
        REG_SRC_ROOM_Y = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
    } div_state_t;
endpackage

// ===== src/nearest_neighbor_resize_mapper.sv =====
// Nearest neighbor resize mapper: destination pixel to nearest source pixel.
// One coordinate word enters per clock unless in_stall is high; each axis has
// a 27-step restoring divider, which retires one quotient bit per pipeline
// stage. Output stall freezes the whole pipeline; no word is lost or repeated.
// Configuration registers are to be written through wr_en/wr_index/wr_data
// while the pipeline is empty; the user is bound, the block does not enforce it.
`include "nearest_neighbor_resize_mapper_assert.svh"
module nearest_neighbor_resize_mapper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [nnrm_pkg::IDX_W-1:0]    wr_index,
    input  logic [nnrm_pkg::REG_W-1:0]    wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nnrm_pkg::COORD_W-1:0]  dst_x,
    input  logic [nnrm_pkg::COORD_W-1:0]  dst_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          copy,
    output logic [nnrm_pkg::COORD_W-1:0]  out_dst_x,
    output logic [nnrm_pkg::COORD_W-1:0]  out_dst_y,
    output logic [nnrm_pkg::REG_W-1:0]    src_x,
    output logic [nnrm_pkg::REG_W-1:0]    src_y
);
    import nnrm_pkg::*;

    logic [REG_W-1:0] dw_reg, dh_reg, sw_reg, sh_reg;
    logic [REG_W-1:0] drx_reg, dry_reg, srx_reg, sry_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dw_reg  <= REG_W'(1);
            dh_reg  <= REG_W'(1);
            sw_reg  <= '0;
            sh_reg  <= '0;
            drx_reg <= '0;
            dry_reg <= '0;
            srx_reg <= '0;
            sry_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_DST_WIDTH:  dw_reg  <= wr_data;
                REG_DST_HEIGHT: dh_reg  <= wr_data;
                REG_SRC_WIDTH:  sw_reg  <= wr_data;
                REG_SRC_HEIGHT: sh_reg  <= wr_data;
                REG_DST_ROOM_X: drx_reg <= wr_data;
                REG_DST_ROOM_Y: dry_reg <= wr_data;
                REG_SRC_ROOM_X: srx_reg <= wr_data;
                REG_SRC_ROOM_Y: sry_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    // One restoring division step: shift in a numerator bit, subtract if it fits
    function automatic div_state_t div_step(input div_state_t s, input logic [DIV_W-1:0] d);
        logic [REM_W-1:0] sh;
        div_state_t       r;
        sh = {s.rem[REM_W-2:0], s.num[NUM_W-1]};
        r.num = {s.num[NUM_W-2:0], 1'b0};
        r.rem = sh;
        if (sh >= {1'b0, d})
        begin
            r.rem    = sh - {1'b0, d};
            r.num[0] = 1'b1;
        end
        return r;
    endfunction

    logic              adv;
    logic [DIV_W-1:0]  divx, divy;

    logic              v0_reg, v1_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [PROD_W-1:0] px_reg, py_reg;

    logic              dv_reg [0:NUM_W];
    logic [COORD_W-1:0] dx_reg [0:NUM_W];
    logic [COORD_W-1:0] dy_reg [0:NUM_W];
    div_state_t        sx_reg [0:NUM_W];
    div_state_t        sy_reg [0:NUM_W];

    logic              ov_reg, copy_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [REG_W-1:0]  srcx_reg, srcy_reg;

    logic [NUM_W-1:0]  qx, qy;
    logic              copy_next;
    logic [REG_W-1:0]  srcx_next, srcy_next;

    // Advance the whole pipe unless the output word is held
    assign adv      = !(ov_reg && out_stall);
    assign in_stall = !adv;
    assign divx     = {dw_reg, 1'b0};
    assign divy     = {dh_reg, 1'b0};

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    // Capture coordinates, then multiply by source size
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= dst_x;
            y0_reg <= dst_y;
            x1_reg <= x0_reg;
            y1_reg <= y0_reg;
            px_reg <= PROD_W'(x0_reg * sw_reg);
            py_reg <= PROD_W'(y0_reg * sh_reg);
        end
    end

    // Form the rounded numerator 2*pos*src + dst
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0]     <= x1_reg;
            dy_reg[0]     <= y1_reg;
            sx_reg[0].rem <= '0;
            sy_reg[0].rem <= '0;
            sx_reg[0].num <= NUM_W'({px_reg, 1'b0}) + NUM_W'(dw_reg);
            sy_reg[0].num <= NUM_W'({py_reg, 1'b0}) + NUM_W'(dh_reg);
        end
    end

    // Divider stages, one quotient bit each
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (adv)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dx_reg[k+1] <= dx_reg[k];
                dy_reg[k+1] <= dy_reg[k];
                sx_reg[k+1] <= div_step(sx_reg[k], divx);
                sy_reg[k+1] <= div_step(sy_reg[k], divy);
            end
        end
    end

    // Saturate, handle zero sizes and check the rooms
    always_comb
    begin
        qx        = sx_reg[NUM_W].num;
        qy        = sy_reg[NUM_W].num;
        srcx_next = (qx[NUM_W-1:REG_W] != '0) ? '1 : qx[REG_W-1:0];
        srcy_next = (qy[NUM_W-1:REG_W] != '0) ? '1 : qy[REG_W-1:0];
        if (dw_reg == '0)
            srcx_next = '0;
        if (dh_reg == '0)
            srcy_next = '0;
        copy_next = (dw_reg != '0) && (dh_reg != '0)
                 && ({1'b0, dx_reg[NUM_W]} < drx_reg)
                 && ({1'b0, dy_reg[NUM_W]} < dry_reg)
                 && (qx < NUM_W'(srx_reg))
                 && (qy < NUM_W'(sry_reg));
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= dv_reg[NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            copy_reg <= copy_next;
            ox_reg   <= dx_reg[NUM_W];
            oy_reg   <= dy_reg[NUM_W];
            srcx_reg <= srcx_next;
            srcy_reg <= srcy_next;
        end
    end

    assign out_valid = ov_reg;
    assign copy      = copy_reg;
    assign out_dst_x = ox_reg;
    assign out_dst_y = oy_reg;
    assign src_x     = srcx_reg;
    assign src_y     = srcy_reg;

    `NNRM_ASSERT(a_stall_only_on_hold, in_stall == (out_valid && out_stall), "input stall without held output")
    `NNRM_ASSERT_IMPL(a_copy_in_room, out_valid && copy, (src_x < srx_reg) && (src_y < sry_reg), "copy outside source room")
    `NNRM_ASSERT_IMPL(a_zero_width, out_valid && (dw_reg == '0), (src_x == '0) && !copy, "zero width not mapped to zero")
endmodule

// ===== tb/sv/tb_nearest_neighbor_resize_mapper.sv =====
// Self-checking testbench for the nearest neighbor resize mapper.
module tb_nearest_neighbor_resize_mapper;
    import nnrm_pkg::*;

    typedef struct {
        logic                copy;
        logic [COORD_W-1:0]  dx;
        logic [COORD_W-1:0]  dy;
        logic [REG_W-1:0]    sx;
        logic [REG_W-1:0]    sy;
    } pixel_map_t;

    // Expected mappings, in order, with the mapper's own register copy
    class map_scoreboard;
        logic [REG_W-1:0] cfg [8];
        pixel_map_t       pending [$];
        int               errors;

        function void clear_cfg();
            foreach (cfg[i]) cfg[i] = '0;
            cfg[REG_DST_WIDTH]  = 1;
            cfg[REG_DST_HEIGHT] = 1;
        endfunction

        // Round half up of pos*src/dst; zero divisor gives zero
        function longint unsigned scale_axis(longint unsigned pos, longint unsigned srcsz,
                                             longint unsigned dstsz);
            if (dstsz == 0)
                return 0;
            return (2 * pos * srcsz + dstsz) / (2 * dstsz);
        endfunction

        function void note_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            longint unsigned sx;
            longint unsigned sy;
            pixel_map_t      m;
            sx = scale_axis(x, cfg[REG_SRC_WIDTH], cfg[REG_DST_WIDTH]);
            sy = scale_axis(y, cfg[REG_SRC_HEIGHT], cfg[REG_DST_HEIGHT]);
            m.copy = (cfg[REG_DST_WIDTH] != 0) && (cfg[REG_DST_HEIGHT] != 0)
                && (x < cfg[REG_DST_ROOM_X]) && (y < cfg[REG_DST_ROOM_Y])
                && (sx < cfg[REG_SRC_ROOM_X]) && (sy < cfg[REG_SRC_ROOM_Y]);
            m.dx = x;
            m.dy = y;
            m.sx = (sx > 8191) ? 13'h1FFF : sx[REG_W-1:0];
            m.sy = (sy > 8191) ? 13'h1FFF : sy[REG_W-1:0];
            pending.push_back(m);
        endfunction

        function void check_word(pixel_map_t got);
            pixel_map_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word copy=%0d x=%0d y=%0d sx=%0d sy=%0d",
                         $time, got.copy, got.dx, got.dy, got.sx, got.sy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.copy !== e.copy || got.dx !== e.dx || got.dy !== e.dy
                || got.sx !== e.sx || got.sy !== e.sy)
            begin
                $display("%0t: mismatch expected copy=%0d x=%0d y=%0d sx=%0d sy=%0d",
                         $time, e.copy, e.dx, e.dy, e.sx, e.sy);
                $display("%0t:          actual   copy=%0d x=%0d y=%0d sx=%0d sy=%0d",
                         $time, got.copy, got.dx, got.dy, got.sx, got.sy);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_index;
    logic [REG_W-1:0]   wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic               out_valid;
    logic               out_stall;
    logic               copy;
    logic [COORD_W-1:0] out_dst_x;
    logic [COORD_W-1:0] out_dst_y;
    logic [REG_W-1:0]   src_x;
    logic [REG_W-1:0]   src_y;

    map_scoreboard sb;
    bit            calm;
    longint        cycles;

    nearest_neighbor_resize_mapper u_dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .dst_x(dst_x), .dst_y(dst_y),
        .out_valid(out_valid), .out_stall(out_stall), .copy(copy),
        .out_dst_x(out_dst_x), .out_dst_y(out_dst_y), .src_x(src_x), .src_y(src_y)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check every accepted result word
    always @(posedge clk)
    begin
        pixel_map_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.copy = copy;
            got.dx   = out_dst_x;
            got.dy   = out_dst_y;
            got.sx   = src_x;
            got.sy   = src_y;
            sb.check_word(got);
        end
    end

    // Stall the output in random bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val[REG_W-1:0];
        sb.cfg[idx] = val[REG_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Present one word and hold it until accepted, sometimes with a random gap first
    task automatic send_word(int unsigned x, int unsigned y);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        dst_x    <= x[COORD_W-1:0];
        dst_y    <= y[COORD_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(x[COORD_W-1:0], y[COORD_W-1:0]);
        @(negedge clk);
    endtask

    // Drop valid right away so the last word is not taken twice
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 4096;
            2: return $urandom_range(1, 16);
            3: return $urandom_range(0, 8191);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_DST_WIDTH, pick_size());
        write_reg(REG_DST_HEIGHT, pick_size());
        write_reg(REG_SRC_WIDTH, pick_size());
        write_reg(REG_SRC_HEIGHT, pick_size());
        write_reg(REG_DST_ROOM_X, pick_size());
        write_reg(REG_DST_ROOM_Y, pick_size());
        write_reg(REG_SRC_ROOM_X, pick_size());
        write_reg(REG_SRC_ROOM_Y, pick_size());
    endtask

    function automatic int unsigned pick_coord(int unsigned lim);
        if ($urandom_range(0, 7) == 0 || lim == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(0, (lim > 4096 ? 4096 : lim) - 1);
    endfunction

    initial
    begin
        sb = new();
        sb.clear_cfg();
        cycles   = 0;
        calm     = 1'b0;
        rst_n    = 1'b0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        in_valid = 1'b0;
        dst_x    = '0;
        dst_y    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: zero source and rooms
        send_word(0, 0);
        send_word(4095, 4095);
        drain();

        // Largest scaling, all rooms at their largest value
        write_reg(REG_DST_WIDTH, 1);
        write_reg(REG_DST_HEIGHT, 1);
        write_reg(REG_SRC_WIDTH, 4096);
        write_reg(REG_SRC_HEIGHT, 4096);
        write_reg(REG_DST_ROOM_X, 8191);
        write_reg(REG_DST_ROOM_Y, 8191);
        write_reg(REG_SRC_ROOM_X, 8191);
        write_reg(REG_SRC_ROOM_Y, 8191);
        send_word(0, 0);
        send_word(1, 1);
        send_word(2, 1);
        send_word(4095, 4095);
        send_word(4095, 0);
        drain();

        // Zero destination size on each axis
        write_reg(REG_DST_WIDTH, 0);
        send_word(5, 0);
        drain();
        write_reg(REG_DST_WIDTH, 3);
        write_reg(REG_DST_HEIGHT, 0);
        send_word(1, 2);
        drain();

        // Half-way rounding and room edges
        write_reg(REG_DST_HEIGHT, 4);
        write_reg(REG_SRC_WIDTH, 2);
        write_reg(REG_SRC_HEIGHT, 2);
        write_reg(REG_DST_ROOM_X, 2);
        write_reg(REG_DST_ROOM_Y, 4);
        write_reg(REG_SRC_ROOM_X, 1);
        write_reg(REG_SRC_ROOM_Y, 2);
        send_word(0, 1);
        send_word(1, 3);
        send_word(2, 2);
        send_word(3, 4);
        send_word(4095, 1);
        drain();

        // Random phases with well-formed raster coordinates mostly
        for (int p = 0; p < 24; p++)
        begin
            random_config();
            if (p >= 21)
                calm = 1'b1;
            for (int i = 0; i < 25; i++)
                send_word(pick_coord(sb.cfg[REG_DST_WIDTH]),
                          pick_coord(sb.cfg[REG_DST_HEIGHT]));
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== nearest_neighbor_resize_mapper.f =====
+incdir+src
src/nnrm_pkg.sv
src/nearest_neighbor_resize_mapper.sv
tb/sv/tb_nearest_neighbor_resize_mapper.sv
